// ===== rtl/bbd_pkg.sv =====
package bbd_pkg;

    localparam int PIX_W          = 8;
    localparam int DIM_W          = 11;
    localparam int MIN_DIM        = 3;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int WIDTH_RST      = 420;
    localparam int HEIGHT_RST     = 288;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 3;

    // register index = paddr[2]
    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_DRAIN  = 1'b1
    } t_cmd;

    // GRBG site kind, encoded {row odd, column odd}
    typedef enum logic [1:0] {
        SITE_GR = 2'b00,
        SITE_R  = 2'b01,
        SITE_B  = 2'b10,
        SITE_GB = 2'b11
    } t_site;

    typedef logic [PIX_W-1:0] t_pix;

    // [row][column], row 0 = top, column 0 = left
    typedef logic [2:0][2:0][PIX_W-1:0] t_nbhd;

    typedef struct packed {
        t_cmd command;
        t_pix raw_sample;
    } t_in_beat;

    typedef struct packed {
        t_pix red;
        t_pix green;
        t_pix blue;
        logic frame_end;
        logic run_last;
    } t_out_beat;

endpackage

// ===== rtl/bbd_if.sv =====
interface bbd_in_if;
    logic             valid;
    logic             ready;
    bbd_pkg::t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bbd_out_if;
    logic              valid;
    logic              ready;
    bbd_pkg::t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bayer_bilinear_demosaic_unit.sv =====
// Bilinear Bayer demosaic, GRBG pattern, for a raster stream of 8-bit raw samples.
// One beat is taken per clock unless the output queue lacks room. Pixel (r, c-1)
// leaves with the sample at (r+1, c), so output runs one row behind input; the
// sample that ends a row also yields the row's last pixel, so that beat gives two
// results. The beat after it opens a row (or the drain) and gives none, so the
// two-entry output queue absorbs the extra result: with the output always ready
// the input never pauses. After the frame's last sample, W drain beats (command = 1)
// flush the final row; the last of them carries frame_end. Beats that do not fit
// the phase (a sample while draining, a drain beat mid-frame) are taken and dropped.
// Borders are mirrored without edge repeat. The two line stores hold undefined data
// after reset and need no clearing pass.
// Registers (APB, 32-bit): 0x0 image_width, 0x4 image_height; values are clamped
// to 3..MAX_WIDTH and 3..MAX_HEIGHT. Write them only between beats of no frame.
module bayer_bilinear_demosaic_unit #(
    parameter int MAX_WIDTH  = bbd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bbd_in_if.sink                         i_pix,
    bbd_out_if.source                      o_rgb,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bbd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bbd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bbd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int DW = bbd_pkg::DIM_W;

    // control carried alongside the line store read
    typedef struct packed {
        logic          valid;
        logic          drain;      // drain beat: bottom row mirrors top
        logic [AW-1:0] addr;       // line slot
        bbd_pkg::t_pix sample;
        logic          emit_prev;  // result for column c-1
        logic          emit_last;  // result for column c (row end)
        logic          first;      // c-1 is column 0: left mirror
        logic          top_mirror; // output row 0: top mirrors bottom
        logic          row_odd;
        logic          col_odd;    // parity of column c-1
        logic          frame_end;
    } t_stage;

    function automatic logic [DW-1:0] clamp_dim(logic [DW-1:0] v, int unsigned hi);
        if (32'(v) < bbd_pkg::MIN_DIM) begin
            return DW'(bbd_pkg::MIN_DIM);
        end
        if (32'(v) > hi) begin
            return DW'(hi);
        end
        return v;
    endfunction

    // ---------------- configuration ----------------
    logic [DW-1:0] r_cfg_w;
    logic [DW-1:0] r_cfg_h;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= DW'(bbd_pkg::WIDTH_RST);
            r_cfg_h <= DW'(bbd_pkg::HEIGHT_RST);
        end else if (cfg_wr) begin
            case (bbd_pkg::t_reg_idx'(paddr[2]))
                bbd_pkg::REG_IMAGE_WIDTH:  r_cfg_w <= pwdata[DW-1:0];
                bbd_pkg::REG_IMAGE_HEIGHT: r_cfg_h <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (bbd_pkg::t_reg_idx'(paddr[2]))
            bbd_pkg::REG_IMAGE_WIDTH:  prdata = bbd_pkg::APB_DATA_W'(r_cfg_w);
            bbd_pkg::REG_IMAGE_HEIGHT: prdata = bbd_pkg::APB_DATA_W'(r_cfg_h);
            default:                   prdata = '0;
        endcase
    end

    // ---------------- position and phase ----------------
    logic [DW-1:0] w_eff, h_eff, w_last, h_last;
    logic [DW-1:0] r_row, r_col, r_drain;
    logic [DW-1:0] pos;
    logic          drain_phase, effective, at_end, in_fire, load;
    logic [AW-1:0] slot;
    t_stage        r_a, n_a;
    logic          a_adv;

    assign w_eff  = clamp_dim(r_cfg_w, MAX_WIDTH);
    assign h_eff  = clamp_dim(r_cfg_h, MAX_HEIGHT);
    assign w_last = w_eff - DW'(1);
    assign h_last = h_eff - DW'(1);

    assign drain_phase = (r_row >= h_eff);
    assign effective   = drain_phase ? (i_pix.data.command == bbd_pkg::CMD_DRAIN)
                                     : (i_pix.data.command == bbd_pkg::CMD_SAMPLE);
    assign pos    = drain_phase ? r_drain : r_col;
    assign at_end = (pos >= w_last);
    assign slot   = (32'(pos) >= MAX_WIDTH) ? AW'(MAX_WIDTH - 1) : AW'(pos);

    assign i_pix.ready = !r_a.valid || a_adv;
    assign in_fire     = i_pix.valid && i_pix.ready;
    assign load        = in_fire && effective;

    always_comb begin
        n_a            = r_a;
        n_a.valid      = 1'b1;
        n_a.drain      = drain_phase;
        n_a.addr       = slot;
        n_a.sample     = i_pix.data.raw_sample;
        n_a.emit_prev  = (pos != '0) && (drain_phase || (r_row != '0));
        n_a.emit_last  = at_end && (drain_phase || (r_row != '0));
        n_a.first      = (pos == DW'(1));
        n_a.top_mirror = !drain_phase && (r_row == DW'(1));
        n_a.row_odd    = drain_phase ? h_last[0] : !r_row[0];
        n_a.col_odd    = !pos[0];
        n_a.frame_end  = drain_phase && at_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_drain <= '0;
        end else if (load) begin
            if (drain_phase) begin
                if (at_end) begin
                    r_row   <= '0;
                    r_col   <= '0;
                    r_drain <= '0;
                end else begin
                    r_drain <= pos + DW'(1);
                end
            end else if (at_end) begin
                r_col   <= '0;
                r_row   <= r_row + DW'(1);
                r_drain <= '0;
            end else begin
                r_col <= pos + DW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
        end else if (load) begin
            r_a.valid <= 1'b1;
        end else if (a_adv) begin
            r_a.valid <= 1'b0;
        end
        if (load) begin
            r_a.drain      <= n_a.drain;
            r_a.addr       <= n_a.addr;
            r_a.sample     <= n_a.sample;
            r_a.emit_prev  <= n_a.emit_prev;
            r_a.emit_last  <= n_a.emit_last;
            r_a.first      <= n_a.first;
            r_a.top_mirror <= n_a.top_mirror;
            r_a.row_odd    <= n_a.row_odd;
            r_a.col_odd    <= n_a.col_odd;
            r_a.frame_end  <= n_a.frame_end;
        end
    end

    // ---------------- line stores ----------------
    // middle line takes the sample at accept; upper line takes the old middle
    // value once it has been read, when the beat leaves the stage
    bbd_pkg::t_pix up_q, mid_q;

    bbd_line_ram #(.DEPTH(MAX_WIDTH), .AW(AW)) u_upper (
        .i_clk   (i_clk),
        .i_we    (a_adv && !r_a.drain),
        .i_waddr (r_a.addr),
        .i_wdata (mid_q),
        .i_re    (load),
        .i_raddr (slot),
        .o_rdata (up_q)
    );

    bbd_line_ram #(.DEPTH(MAX_WIDTH), .AW(AW)) u_middle (
        .i_clk   (i_clk),
        .i_we    (load && !drain_phase),
        .i_waddr (slot),
        .i_wdata (i_pix.data.raw_sample),
        .i_re    (load),
        .i_raddr (slot),
        .o_rdata (mid_q)
    );

    // ---------------- 3x3 window ----------------
    bbd_pkg::t_nbhd r_win, n_win, src_win, nb_prev, nb_last;
    logic [1:0]     left_col;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = up_q;
        n_win[1][2] = mid_q;
        n_win[2][2] = r_a.drain ? up_q : r_a.sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (a_adv) begin
            r_win <= n_win;
        end
    end

    assign left_col = r_a.first ? 2'd2 : 2'd0;

    always_comb begin
        src_win    = n_win;
        src_win[0] = r_a.top_mirror ? n_win[2] : n_win[0];
        for (int r = 0; r < 3; r++) begin
            nb_prev[r][0] = src_win[r][left_col];
            nb_prev[r][1] = src_win[r][1];
            nb_prev[r][2] = src_win[r][2];
            // right border: column W reads column W-2
            nb_last[r][0] = src_win[r][1];
            nb_last[r][1] = src_win[r][2];
            nb_last[r][2] = src_win[r][1];
        end
    end

    // ---------------- interpolation ----------------
    bbd_pkg::t_out_beat px_prev, px_last, beat0, beat1;
    logic               any_res, two_res, q_room;

    bbd_interp u_interp_prev (
        .i_nb    (nb_prev),
        .i_site  (bbd_pkg::t_site'({r_a.row_odd, r_a.col_odd})),
        .o_red   (px_prev.red),
        .o_green (px_prev.green),
        .o_blue  (px_prev.blue)
    );

    bbd_interp u_interp_last (
        .i_nb    (nb_last),
        .i_site  (bbd_pkg::t_site'({r_a.row_odd, !r_a.col_odd})),
        .o_red   (px_last.red),
        .o_green (px_last.green),
        .o_blue  (px_last.blue)
    );

    assign px_prev.frame_end = 1'b0;
    assign px_prev.run_last  = 1'b0;
    assign px_last.frame_end = r_a.frame_end;
    assign px_last.run_last  = 1'b1;

    assign any_res = r_a.emit_prev || r_a.emit_last;
    assign two_res = r_a.emit_prev && r_a.emit_last;
    assign a_adv   = r_a.valid && (!any_res || q_room);

    always_comb begin
        beat0          = r_a.emit_prev ? px_prev : px_last;
        beat0.run_last = !two_res;
        beat1          = px_last;
    end

    bbd_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (a_adv && any_res),
        .i_two   (two_res),
        .i_beat0 (beat0),
        .i_beat1 (beat1),
        .o_room  (q_room),
        .o_rgb   (o_rgb)
    );

    // ---------------- assertions ----------------
    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a.valid && !a_adv |=> r_a.valid && $stable(r_a.addr) && $stable(r_a.sample))
        else $error("stalled stage lost its beat");

    a_dropped_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && !effective |=> !r_a.valid)
        else $error("dropped beat entered the stage");

    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rgb.valid && o_rgb.data.frame_end |-> o_rgb.data.run_last)
        else $error("frame_end not on last result of a beat");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_col) < MAX_WIDTH) && (32'(r_drain) < MAX_WIDTH))
        else $error("column counter beyond line store");

endmodule

// ===== rtl/bbd_line_ram.sv =====
module bbd_line_ram #(
    parameter int DEPTH = bbd_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  bbd_pkg::t_pix i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output bbd_pkg::t_pix o_rdata
);

    bbd_pkg::t_pix r_mem [DEPTH];
    bbd_pkg::t_pix r_rdata;

    // read-first: a read and write to one address in one cycle returns old data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bbd_interp.sv =====
module bbd_interp (
    input  bbd_pkg::t_nbhd i_nb,
    input  bbd_pkg::t_site i_site,
    output bbd_pkg::t_pix  o_red,
    output bbd_pkg::t_pix  o_green,
    output bbd_pkg::t_pix  o_blue
);

    logic [bbd_pkg::PIX_W:0]   sum_h;
    logic [bbd_pkg::PIX_W:0]   sum_v;
    logic [bbd_pkg::PIX_W+1:0] sum_cr;
    logic [bbd_pkg::PIX_W+1:0] sum_dg;
    bbd_pkg::t_pix             avg_h;
    bbd_pkg::t_pix             avg_v;
    bbd_pkg::t_pix             avg_cr;
    bbd_pkg::t_pix             avg_dg;
    bbd_pkg::t_pix             ctr;

    assign sum_h  = (bbd_pkg::PIX_W+1)'(i_nb[1][0]) + (bbd_pkg::PIX_W+1)'(i_nb[1][2]);
    assign sum_v  = (bbd_pkg::PIX_W+1)'(i_nb[0][1]) + (bbd_pkg::PIX_W+1)'(i_nb[2][1]);
    assign sum_cr = (bbd_pkg::PIX_W+2)'(sum_h) + (bbd_pkg::PIX_W+2)'(sum_v);
    assign sum_dg = (bbd_pkg::PIX_W+2)'(i_nb[0][0]) + (bbd_pkg::PIX_W+2)'(i_nb[0][2])
                  + (bbd_pkg::PIX_W+2)'(i_nb[2][0]) + (bbd_pkg::PIX_W+2)'(i_nb[2][2]);

    // floor averages
    assign avg_h  = sum_h[bbd_pkg::PIX_W:1];
    assign avg_v  = sum_v[bbd_pkg::PIX_W:1];
    assign avg_cr = sum_cr[bbd_pkg::PIX_W+1:2];
    assign avg_dg = sum_dg[bbd_pkg::PIX_W+1:2];
    assign ctr    = i_nb[1][1];

    always_comb begin
        case (i_site)
            bbd_pkg::SITE_GR: begin
                o_red   = avg_h;
                o_green = ctr;
                o_blue  = avg_v;
            end
            bbd_pkg::SITE_GB: begin
                o_red   = avg_v;
                o_green = ctr;
                o_blue  = avg_h;
            end
            bbd_pkg::SITE_B: begin
                o_red   = avg_dg;
                o_green = avg_cr;
                o_blue  = ctr;
            end
            default: begin
                o_red   = ctr;
                o_green = avg_cr;
                o_blue  = avg_dg;
            end
        endcase
    end

endmodule

// ===== rtl/bbd_out_queue.sv =====
module bbd_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_two,
    input  bbd_pkg::t_out_beat i_beat0,
    input  bbd_pkg::t_out_beat i_beat1,
    output logic               o_room,
    bbd_out_if.source          o_rgb
);

    logic [1:0]         r_cnt;
    bbd_pkg::t_out_beat r_q0;
    bbd_pkg::t_out_beat r_q1;
    logic               pop;

    assign o_rgb.valid = (r_cnt != 2'd0);
    assign o_rgb.data  = r_q0;
    assign pop         = o_rgb.valid && o_rgb.ready;

    // loads only into a queue that is empty after this cycle's pop
    assign o_room = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_two ? 2'd2 : 2'd1;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q0 <= i_beat0;
            r_q1 <= i_beat1;
        end else if (pop) begin
            r_q0 <= r_q1;
        end
    end

endmodule
